[rtl/assert_macros.svh]
// Assertion macros shared by the transliterator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant assertion failed");

// A condition that must hold in the cycle after its trigger, outside reset.
`define ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("next-cycle assertion failed");

`endif

[rtl/utf8l1_pkg.sv]
// Shared widths, constants, result type and Latin-1 folding function of the transliterator.
package utf8l1_pkg;

  localparam int BYTE_W  = 8;
  localparam int CHAR_W  = 7;
  localparam int COUNT_W = 10;

  // Hard ceiling on characters per string, applied on top of the programmed limit.
  localparam int MAX_LENGTH = 1023;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(255);

  localparam logic [BYTE_W-1:0] BYTE_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] BYTE_TAB  = 8'h09;
  localparam logic [BYTE_W-1:0] BYTE_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_ASCII_END = 8'h80;
  localparam logic [BYTE_W-1:0] BYTE_LEAD_C2 = 8'hC2;
  localparam logic [BYTE_W-1:0] BYTE_LEAD_C3 = 8'hC3;
  localparam logic [BYTE_W-1:0] BYTE_LEAD_3B = 8'hE0;
  localparam logic [BYTE_W-1:0] BYTE_LEAD_4B = 8'hF0;
  localparam logic [BYTE_W-1:0] BYTE_UPPER_END = 8'hA0;
  localparam logic [BYTE_W-1:0] BYTE_SHARP_S = 8'h9F;
  localparam logic [BYTE_W-1:0] BYTE_Y_DIAER = 8'hBF;

  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_QMARK = 7'h3F;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
  localparam logic [CHAR_W-1:0] CH_C     = 7'h63;
  localparam logic [CHAR_W-1:0] CH_E     = 7'h65;
  localparam logic [CHAR_W-1:0] CH_I     = 7'h69;
  localparam logic [CHAR_W-1:0] CH_N     = 7'h6E;
  localparam logic [CHAR_W-1:0] CH_O     = 7'h6F;
  localparam logic [CHAR_W-1:0] CH_S     = 7'h73;
  localparam logic [CHAR_W-1:0] CH_U     = 7'h75;
  localparam logic [CHAR_W-1:0] CH_Y     = 7'h79;
  localparam logic [CHAR_W-1:0] CASE_BIT = 7'h20;

  typedef struct packed {
    logic [COUNT_W-1:0] spaces_before;
    logic [CHAR_W-1:0]  out_char;
    logic               has_char;
    logic               done_res;
    logic [COUNT_W-1:0] length;
  } res_t;

  // Folds the continuation byte of a C3 pair to its base letter, or '?'.
  function automatic logic [CHAR_W-1:0] fold_c3(input logic [BYTE_W-1:0] d);
    logic              up;
    logic [4:0]        lo;
    logic [CHAR_W-1:0] base;
    logic              known;
    logic [CHAR_W-1:0] ch;
    up    = (d < BYTE_UPPER_END);
    lo    = d[4:0];
    base  = CH_QMARK;
    known = 1'b1;
    case (lo) inside
      [5'h00:5'h05]:        base = CH_A;
      5'h07:                base = CH_C;
      [5'h08:5'h0B]:        base = CH_E;
      [5'h0C:5'h0F]:        base = CH_I;
      5'h11:                base = CH_N;
      [5'h12:5'h16], 5'h18: base = CH_O;
      [5'h19:5'h1C]:        base = CH_U;
      default:              known = 1'b0;
    endcase
    if (d[7:6] != 2'b10) begin
      ch = CH_QMARK;
    end else if (d == BYTE_SHARP_S) begin
      ch = CH_S;
    end else if (d == BYTE_Y_DIAER) begin
      ch = CH_Y;
    end else if (!known) begin
      ch = CH_QMARK;
    end else if (up) begin
      ch = base ^ CASE_BIT;
    end else begin
      ch = base;
    end
    return ch;
  endfunction

endpackage

[rtl/utf8l1_core.sv]
// Sequence state, space and length counters, and the per-byte translation step.
`include "assert_macros.svh"

module utf8l1_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [utf8l1_pkg::BYTE_W-1:0]   in_byte,
  input  logic                            end_mark,
  input  logic [utf8l1_pkg::COUNT_W-1:0]  out_limit,
  output utf8l1_pkg::res_t                res,
  output logic                            res_valid
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_C2   = 2'd1,
    MODE_C3   = 2'd2,
    MODE_SKIP = 2'd3
  } mode_t;

  mode_t                          seq_mode, seq_mode_next;
  logic [1:0]                     skip_left, skip_left_next;
  logic [utf8l1_pkg::COUNT_W-1:0] held_spaces, held_spaces_next;
  logic [utf8l1_pkg::COUNT_W-1:0] emitted_count, emitted_count_next;

  logic                           end_in;
  logic [utf8l1_pkg::COUNT_W-1:0] limit;
  logic                           prod;
  logic [utf8l1_pkg::CHAR_W-1:0]  prod_ch;

  assign end_in = end_mark || (in_byte == utf8l1_pkg::BYTE_NUL);

  always_comb begin
    if (int'(out_limit) > utf8l1_pkg::MAX_LENGTH) begin
      limit = utf8l1_pkg::COUNT_W'(utf8l1_pkg::MAX_LENGTH);
    end else begin
      limit = out_limit;
    end
  end

  always_comb begin
    seq_mode_next      = seq_mode;
    skip_left_next     = skip_left;
    held_spaces_next   = held_spaces;
    emitted_count_next = emitted_count;
    res                = '0;
    res_valid          = 1'b0;
    prod               = 1'b0;
    prod_ch            = utf8l1_pkg::CH_QMARK;

    if (end_in) begin
      // A lead byte left hanging at the end turns into '?' in the final item.
      res.done_res = 1'b1;
      res_valid    = 1'b1;
      if (seq_mode == MODE_C2 || seq_mode == MODE_C3) begin
        res.spaces_before = held_spaces;
        res.out_char      = utf8l1_pkg::CH_QMARK;
        res.has_char      = 1'b1;
        res.length        = emitted_count + 1'b1;
      end else begin
        res.length        = emitted_count - held_spaces;
      end
      seq_mode_next      = MODE_IDLE;
      skip_left_next     = '0;
      held_spaces_next   = '0;
      emitted_count_next = '0;
    end else begin
      case (seq_mode)
        MODE_C2: begin
          prod          = 1'b1;
          prod_ch       = utf8l1_pkg::CH_SPACE;
          seq_mode_next = MODE_IDLE;
        end
        MODE_C3: begin
          prod          = 1'b1;
          prod_ch       = utf8l1_pkg::fold_c3(in_byte);
          seq_mode_next = MODE_IDLE;
        end
        MODE_SKIP: begin
          if (skip_left <= 2'd1) begin
            skip_left_next = '0;
            seq_mode_next  = MODE_IDLE;
          end else begin
            skip_left_next = skip_left - 2'd1;
          end
        end
        default: begin
          if (emitted_count >= limit) begin
            prod = 1'b0;
          end else if (in_byte < utf8l1_pkg::BYTE_ASCII_END) begin
            prod = 1'b1;
            if (in_byte == utf8l1_pkg::BYTE_CR || in_byte == utf8l1_pkg::BYTE_LF ||
                in_byte == utf8l1_pkg::BYTE_TAB) begin
              prod_ch = utf8l1_pkg::CH_SPACE;
            end else begin
              prod_ch = in_byte[utf8l1_pkg::CHAR_W-1:0];
            end
          end else if (in_byte == utf8l1_pkg::BYTE_LEAD_C2) begin
            seq_mode_next = MODE_C2;
          end else if (in_byte == utf8l1_pkg::BYTE_LEAD_C3) begin
            seq_mode_next = MODE_C3;
          end else begin
            prod          = 1'b1;
            prod_ch       = utf8l1_pkg::CH_QMARK;
            seq_mode_next = MODE_SKIP;
            if (in_byte >= utf8l1_pkg::BYTE_LEAD_4B) begin
              skip_left_next = 2'd3;
            end else if (in_byte >= utf8l1_pkg::BYTE_LEAD_3B) begin
              skip_left_next = 2'd2;
            end else begin
              skip_left_next = 2'd1;
            end
          end
        end
      endcase

      if (prod) begin
        emitted_count_next = emitted_count + 1'b1;
        if (prod_ch == utf8l1_pkg::CH_SPACE) begin
          held_spaces_next = held_spaces + 1'b1;
        end else begin
          res.spaces_before = held_spaces;
          res.out_char      = prod_ch;
          res.has_char      = 1'b1;
          res_valid         = 1'b1;
          held_spaces_next  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_mode      <= MODE_IDLE;
      skip_left     <= '0;
      held_spaces   <= '0;
      emitted_count <= '0;
    end else if (go) begin
      seq_mode      <= seq_mode_next;
      skip_left     <= skip_left_next;
      held_spaces   <= held_spaces_next;
      emitted_count <= emitted_count_next;
    end
  end

  `ASSERT_ALWAYS(a_held_within_count, clk, rst, held_spaces <= emitted_count)
  `ASSERT_ALWAYS(a_skip_has_work, clk, rst, (seq_mode != MODE_SKIP) || (skip_left != 2'd0))
  `ASSERT_NEXT(a_end_clears, clk, rst, go && end_in, (emitted_count == '0) && (held_spaces == '0) && (seq_mode == MODE_IDLE))

endmodule

[rtl/utf8_latin1_transliterator_unit.sv]
// Top level of the UTF-8 to ASCII transliterator: input stage, limit register, result register.
// An accepted item is held in the input stage; its result is then registered in the result
// register. Throughput: one item per cycle, set by the single translation step between
// the input register and the result register, while the output side takes results.
// Bytes that produce nothing (held spaces, lead bytes, skipped bytes) leave no result.
// Reset is synchronous and active high; it empties both stages, sets the limit to 255 and
// returns the sequence state and counters to idle and zero.
`include "assert_macros.svh"

module utf8_latin1_transliterator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [utf8l1_pkg::BYTE_W-1:0]   in_byte,
  input  logic                            end_mark,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [utf8l1_pkg::COUNT_W-1:0]  spaces_before,
  output logic [utf8l1_pkg::CHAR_W-1:0]   out_char,
  output logic                            has_char,
  output logic                            done_res,
  output logic [utf8l1_pkg::COUNT_W-1:0]  length,
  input  logic                            cfg_wr_en,
  input  logic [utf8l1_pkg::COUNT_W-1:0]  cfg_wr_data
);

  // The user must write the limit register only while no item is in flight; the block does not enforce it.
  logic [utf8l1_pkg::COUNT_W-1:0] out_limit;

  // Input stage: holds one accepted item until the result register can take its outcome.
  logic                          s1_valid;
  logic [utf8l1_pkg::BYTE_W-1:0] s1_byte;
  logic                          s1_end;

  // Result register, decoupling the output handshake from the translation step.
  utf8l1_pkg::res_t res_q;
  utf8l1_pkg::res_t step_res;
  logic             step_res_valid;

  logic out_free;
  logic go;
  logic in_fire;

  // The staged item is processed whenever the result register is free or being emptied,
  // so a result waiting on the output holds the input only once the input stage is full too.
  assign out_free = !out_valid || out_ready;
  assign go       = s1_valid && out_free;
  assign in_ready = !s1_valid || go;
  assign in_fire  = in_valid && in_ready;

  utf8l1_core u_core (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .in_byte   (s1_byte),
    .end_mark  (s1_end),
    .out_limit (out_limit),
    .res       (step_res),
    .res_valid (step_res_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= utf8l1_pkg::LIMIT_RESET;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        out_limit <= cfg_wr_data;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (go) begin
        s1_valid <= 1'b0;
      end
      if (go) begin
        out_valid <= step_res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte <= in_byte;
      s1_end  <= end_mark;
    end
    if (go && step_res_valid) begin
      res_q <= step_res;
    end
  end

  assign spaces_before = res_q.spaces_before;
  assign out_char      = res_q.out_char;
  assign has_char      = res_q.has_char;
  assign done_res      = res_q.done_res;
  assign length        = res_q.length;

  `ASSERT_ALWAYS(a_ready_when_empty, clk, rst, s1_valid || in_ready)
  `ASSERT_NEXT(a_stage_kept, clk, rst, s1_valid && !go, s1_valid)
  `ASSERT_NEXT(a_result_kept, clk, rst, out_valid && !out_ready, out_valid && $stable(res_q))

endmodule
